>>> src/psm_pkg.sv
// Shared types, codes and the CRC-16 step for the packet serial master.
package psm_pkg;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_RX_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    localparam logic [1:0] KIND_WRITE      = 2'd0;
    localparam logic [1:0] KIND_WRITE_DATA = 2'd1;
    localparam logic [1:0] KIND_READ_WORDS = 2'd2;
    localparam logic [1:0] KIND_READ_HALF  = 2'd3;

    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_TICKS  = 2'd1;
    localparam logic [1:0] REG_MAX_RETRIES    = 2'd2;

    localparam logic [7:0]  ACK_BYTE = 8'hFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam int FRAME_MAX = 5;
    localparam int COUNT_W   = 3;

    typedef struct packed {
        logic                      load;
        logic                      is_finish;
        logic [COUNT_W-1:0]        count;
        logic [FRAME_MAX-1:0][7:0] bytes;
        logic                      status;
        logic [31:0]               first_value;
        logic [31:0]               second_value;
    } burst_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> src/packet_serial_master_crc16.sv
// Top level of the packet serial master: input register, core and result buffer.
// Host side of a packet serial motor-controller link with CRC-16 (poly 0x1021,
// init 0). Input items are start requests, received bytes and timer ticks; each
// is registered, processed by the core and its results (up to five frame bytes,
// or one finish item carrying status and read words) are loaded into a result
// buffer that drains one item per cycle, while m_tready is high, on the master
// side. An item goes through the input register, then the result buffer, to its
// first result; a new item is taken every cycle while the buffer is empty or
// hands over its final result, so an item with n results (n from 0 to 5) holds
// the output for all of them, and the single-result-per-cycle port sets the sustained rate.
module packet_serial_master_crc16 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // request_kind[1:0], command_code[9:2], data_byte[17:10],
                                   // rx_byte[25:18], zero fill[31:26]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // tx_byte[7:0], status[8], first_value[40:9],
                                   // second_value[72:41], zero fill[79:73]
    output logic        m_tuser,   // result_kind[0]
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import psm_pkg::*;

    logic [7:0]  dev_addr_reg;
    logic [15:0] timeout_reg;
    logic [3:0]  max_retries_reg;

    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [1:0]  in_kind_reg;
    logic [7:0]  in_cmd_reg;
    logic [7:0]  in_data_reg;
    logic [7:0]  in_rx_reg;

    logic [COUNT_W-1:0]        buf_count_reg;
    logic [FRAME_MAX-1:0][7:0] buf_bytes_reg;
    logic                      buf_finish_reg;
    logic                      buf_status_reg;
    logic [31:0]               buf_v1_reg;
    logic [31:0]               buf_v2_reg;

    logic   buf_free, advance, s_fire, m_take, load;
    burst_t burst;

    assign buf_free = (buf_count_reg == '0) ||
                      ((buf_count_reg == COUNT_W'(1)) && m_tready);
    assign advance  = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign m_take   = m_tvalid && m_tready;
    assign load     = advance && burst.load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg    <= 8'd128;
            timeout_reg     <= 16'd1000;
            max_retries_reg <= 4'd2;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DEVICE_ADDRESS: dev_addr_reg    <= cfg_wdata[7:0];
                REG_TIMEOUT_TICKS:  timeout_reg     <= cfg_wdata;
                REG_MAX_RETRIES:    max_retries_reg <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_op_reg   <= s_tuser;
            in_kind_reg <= s_tdata[1:0];
            in_cmd_reg  <= s_tdata[9:2];
            in_data_reg <= s_tdata[17:10];
            in_rx_reg   <= s_tdata[25:18];
        end
    end

    psm_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_en        (advance),
        .opcode         (in_op_reg),
        .request_kind   (in_kind_reg),
        .command_code   (in_cmd_reg),
        .data_byte      (in_data_reg),
        .rx_byte        (in_rx_reg),
        .device_address (dev_addr_reg),
        .timeout_ticks  (timeout_reg),
        .max_retries    (max_retries_reg),
        .burst          (burst)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_count_reg <= '0;
        end else if (load) begin
            buf_count_reg <= burst.count;
        end else if (m_take) begin
            buf_count_reg <= buf_count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            buf_bytes_reg  <= burst.bytes;
            buf_finish_reg <= burst.is_finish;
            buf_status_reg <= burst.status;
            buf_v1_reg     <= burst.first_value;
            buf_v2_reg     <= burst.second_value;
        end else if (m_take) begin
            buf_bytes_reg <= {8'h00, buf_bytes_reg[FRAME_MAX-1:1]};
        end
    end

    assign m_tvalid = (buf_count_reg != '0);
    assign m_tlast  = (buf_count_reg == COUNT_W'(1));
    assign m_tuser  = buf_finish_reg;
    assign m_tdata  = {7'b0, buf_v2_reg, buf_v1_reg, buf_status_reg, buf_bytes_reg[0]};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_count_reg <= COUNT_W'(FRAME_MAX))
        else $error("result buffer count out of range");

    a_finish_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("finish item not marked last");

    a_drain_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_take && !load) |=> (buf_count_reg == $past(buf_count_reg) - COUNT_W'(1)))
        else $error("result buffer did not advance by one item");

endmodule

>>> src/psm_core.sv
// Transaction state, frame builder and reply checker of the packet serial master.
module psm_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_en,
    input  logic [1:0]       opcode,
    input  logic [1:0]       request_kind,
    input  logic [7:0]       command_code,
    input  logic [7:0]       data_byte,
    input  logic [7:0]       rx_byte,
    input  logic [7:0]       device_address,
    input  logic [15:0]      timeout_ticks,
    input  logic [3:0]       max_retries,
    output psm_pkg::burst_t  burst
);
    import psm_pkg::*;

    logic        busy_reg, busy_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  data_reg, data_next;
    logic [15:0] crc_reg, crc_next;
    logic [3:0]  count_reg, count_next;
    logic [3:0]  retries_reg, retries_next;
    logic [15:0] idle_reg, idle_next;
    logic [31:0] word_one_reg, word_one_next;
    logic [31:0] word_two_reg, word_two_next;
    logic [15:0] crc_rx_reg, crc_rx_next;

    logic [1:0]  frame_kind;
    logic [7:0]  frame_cmd;
    logic [7:0]  frame_data;
    logic [15:0] crc_addr, crc_cmd, crc_data, frame_crc;
    logic [15:0] idle_inc;
    logic [15:0] rx_crc;
    logic [15:0] crc_full;
    logic [3:0]  reply_len;
    logic        do_frame, do_finish, retry, fin_status;
    logic [31:0] fin_v1, fin_v2;

    assign frame_kind = (opcode == OP_START) ? request_kind : kind_reg;
    assign frame_cmd  = (opcode == OP_START) ? command_code : cmd_reg;
    assign frame_data = (opcode == OP_START) ? data_byte : data_reg;
    assign crc_addr   = crc_byte(16'h0000, device_address);
    assign crc_cmd    = crc_byte(crc_addr, frame_cmd);
    assign crc_data   = crc_byte(crc_cmd, frame_data);
    assign frame_crc  = (frame_kind == KIND_WRITE_DATA) ? crc_data : crc_cmd;
    assign idle_inc   = (idle_reg != 16'hFFFF) ? idle_reg + 16'd1 : idle_reg;
    assign rx_crc     = crc_byte(crc_reg, rx_byte);
    assign crc_full   = {crc_rx_reg[15:8], rx_byte};
    assign reply_len  = (kind_reg == KIND_READ_WORDS) ? 4'd8 : 4'd2;

    always_comb begin
        busy_next     = busy_reg;
        kind_next     = kind_reg;
        cmd_next      = cmd_reg;
        data_next     = data_reg;
        crc_next      = crc_reg;
        count_next    = count_reg;
        retries_next  = retries_reg;
        idle_next     = idle_reg;
        word_one_next = word_one_reg;
        word_two_next = word_two_reg;
        crc_rx_next   = crc_rx_reg;
        do_frame      = 1'b0;
        do_finish     = 1'b0;
        retry         = 1'b0;
        fin_status    = 1'b0;
        fin_v1        = 32'h0;
        fin_v2        = 32'h0;
        burst         = '0;

        if (item_en) begin
            case (opcode)
                OP_START: begin
                    if (!busy_reg) begin
                        kind_next    = request_kind;
                        cmd_next     = command_code;
                        data_next    = data_byte;
                        retries_next = max_retries;
                        busy_next    = 1'b1;
                        do_frame     = 1'b1;
                    end
                end
                OP_RX_BYTE: begin
                    if (busy_reg) begin
                        idle_next = 16'h0;
                        if (!kind_reg[1]) begin
                            if (rx_byte == ACK_BYTE) begin
                                do_finish = 1'b1;
                            end else begin
                                retry = 1'b1;
                            end
                        end else if (count_reg < reply_len) begin
                            crc_next = rx_crc;
                            if (count_reg < 4'd4) begin
                                word_one_next = {word_one_reg[23:0], rx_byte};
                            end else begin
                                word_two_next = {word_two_reg[23:0], rx_byte};
                            end
                            count_next = count_reg + 4'd1;
                        end else if (count_reg == reply_len) begin
                            crc_rx_next = {rx_byte, 8'h00};
                            count_next  = count_reg + 4'd1;
                        end else begin
                            crc_rx_next = crc_full;
                            count_next  = 4'd0;
                            if (crc_full == crc_reg) begin
                                do_finish = 1'b1;
                                fin_v1    = word_one_reg;
                                fin_v2    = (kind_reg == KIND_READ_WORDS) ? word_two_reg : 32'h0;
                            end else begin
                                retry = 1'b1;
                            end
                        end
                    end
                end
                OP_TICK: begin
                    if (busy_reg) begin
                        idle_next = idle_inc;
                        if (idle_inc >= timeout_ticks) begin
                            retry = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (retry) begin
            if (retries_reg != 4'd0) begin
                retries_next = retries_reg - 4'd1;
                do_frame     = 1'b1;
            end else begin
                do_finish  = 1'b1;
                fin_status = 1'b1;
            end
        end

        if (do_finish) begin
            busy_next          = 1'b0;
            burst.load         = 1'b1;
            burst.is_finish    = 1'b1;
            burst.count        = COUNT_W'(1);
            burst.status       = fin_status;
            burst.first_value  = fin_v1;
            burst.second_value = fin_v2;
        end

        if (do_frame) begin
            crc_next      = frame_crc;
            count_next    = 4'd0;
            idle_next     = 16'h0;
            word_one_next = 32'h0;
            word_two_next = 32'h0;
            crc_rx_next   = 16'h0;
            burst.load     = 1'b1;
            burst.bytes[0] = device_address;
            burst.bytes[1] = frame_cmd;
            case (frame_kind)
                KIND_WRITE: begin
                    burst.bytes[2] = frame_crc[15:8];
                    burst.bytes[3] = frame_crc[7:0];
                    burst.count    = COUNT_W'(4);
                end
                KIND_WRITE_DATA: begin
                    burst.bytes[2] = frame_data;
                    burst.bytes[3] = frame_crc[15:8];
                    burst.bytes[4] = frame_crc[7:0];
                    burst.count    = COUNT_W'(5);
                end
                default: begin
                    burst.count = COUNT_W'(2);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            kind_reg     <= 2'd0;
            cmd_reg      <= 8'h0;
            data_reg     <= 8'h0;
            crc_reg      <= 16'h0;
            count_reg    <= 4'd0;
            retries_reg  <= 4'd0;
            idle_reg     <= 16'h0;
            word_one_reg <= 32'h0;
            word_two_reg <= 32'h0;
            crc_rx_reg   <= 16'h0;
        end else begin
            busy_reg     <= busy_next;
            kind_reg     <= kind_next;
            cmd_reg      <= cmd_next;
            data_reg     <= data_next;
            crc_reg      <= crc_next;
            count_reg    <= count_next;
            retries_reg  <= retries_next;
            idle_reg     <= idle_next;
            word_one_reg <= word_one_next;
            word_two_reg <= word_two_next;
            crc_rx_reg   <= crc_rx_next;
        end
    end

    a_finish_clears_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_en && burst.load && burst.is_finish) |=> !busy_reg)
        else $error("busy still set after a finish item");

    a_frame_sets_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_en && burst.load && !burst.is_finish) |=> busy_reg)
        else $error("frame sent without an open transaction");

    a_reply_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 4'd9)
        else $error("reply byte count out of range");

endmodule
